// File: hw/rtl/dicomdf_pkg.sv
// Shared types, codes and constants of the DICOM element header deframer.
package dicomdf_pkg;

   localparam int unsigned PREAMBLE_BYTES = 128;

   localparam logic [31:0] MAGIC_WORD   = 32'h4D43_4944;  // "DICM", first byte low
   localparam logic [31:0] TAG_ITEM     = 32'hFFFE_E000;
   localparam logic [31:0] TAG_ITEM_END = 32'hFFFE_E00D;
   localparam logic [31:0] TAG_SEQ_END  = 32'hFFFE_E0DD;
   localparam logic [31:0] LEN_UNDEF    = 32'hFFFF_FFFF;

   localparam logic [15:0] VR_OB = 16'h424F;
   localparam logic [15:0] VR_OW = 16'h574F;
   localparam logic [15:0] VR_SQ = 16'h5153;
   localparam logic [15:0] VR_UT = 16'h5455;

   localparam logic [0:0] CSR_IDX_EXPECT_PREAMBLE = 1'b0;

   typedef enum logic [2:0] {
      PH_PRE   = 3'd0,
      PH_MAGIC = 3'd1,
      PH_TAG   = 3'd2,
      PH_VR    = 3'd3,
      PH_LEN   = 3'd4,
      PH_SKIP  = 3'd5,
      PH_VAL   = 3'd6,
      PH_HALT  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_ITEM     = 3'd1,
      KIND_ITEM_END = 3'd2,
      KIND_SEQ_END  = 3'd3,
      KIND_VALUE    = 3'd4,
      KIND_NOT_DCM  = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] element_tag;
      logic [15:0] value_repr;
      logic [31:0] elem_length;
      logic [7:0]  value_byte;
      logic        last_value;
   } result_type;

   // VRs with two reserved bytes and a 4-byte length
   function automatic logic long_form(input logic [15:0] vr);
      return (vr == VR_OB) || (vr == VR_OW) || (vr == VR_SQ) || (vr == VR_UT);
   endfunction

endpackage

// File: hw/rtl/dicomdf_step.sv
// Parser state and per-byte framing logic of the deframer.
module dicomdf_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    expect_preamble,
   input  logic                    step_en,
   input  logic [7:0]              step_byte,
   input  logic                    step_restart,
   output logic                    res_valid,
   output dicomdf_pkg::result_type res
);

   dicomdf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [31:0] tag_ff, tag_in;
   logic [15:0] vr_ff, vr_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] remain_ff, remain_in;

   always_comb begin
      logic done;
      logic last;
      done      = 1'b0;
      last      = 1'b0;
      phase_in  = phase_ff;
      count_in  = count_ff;
      tag_in    = tag_ff;
      vr_in     = vr_ff;
      len_in    = len_ff;
      remain_in = remain_ff;
      res_valid = 1'b0;
      res       = '0;

      if (step_restart) begin
         phase_in  = expect_preamble ? dicomdf_pkg::PH_PRE : dicomdf_pkg::PH_TAG;
         count_in  = '0;
         tag_in    = '0;
         vr_in     = '0;
         len_in    = '0;
         remain_in = '0;
      end

      // preamble: drop bytes until the count is full, then treat this byte as magic
      if (phase_in == dicomdf_pkg::PH_PRE) begin
         if (count_in < 8'(dicomdf_pkg::PREAMBLE_BYTES)) begin
            count_in = count_in + 8'd1;
            done     = 1'b1;
         end else begin
            phase_in = dicomdf_pkg::PH_MAGIC;
            count_in = '0;
            tag_in   = '0;
         end
      end

      if (!done) begin
         case (phase_in)
            dicomdf_pkg::PH_MAGIC: begin
               tag_in   = tag_in | (32'(step_byte) << {count_in[1:0], 3'b000});
               count_in = count_in + 8'd1;
               if (count_in >= 8'd4) begin
                  count_in = '0;
                  if (tag_in == dicomdf_pkg::MAGIC_WORD) begin
                     phase_in = dicomdf_pkg::PH_TAG;
                  end else begin
                     phase_in      = dicomdf_pkg::PH_HALT;
                     res_valid     = 1'b1;
                     res.kind      = dicomdf_pkg::KIND_NOT_DCM;
                  end
                  tag_in = '0;
               end
            end
            dicomdf_pkg::PH_TAG: begin
               tag_in   = tag_in | (32'(step_byte) << {count_in[1:0], 3'b000});
               count_in = count_in + 8'd1;
               if (count_in >= 8'd4) begin
                  count_in = '0;
                  // group word to the upper half
                  tag_in   = {tag_in[15:0], tag_in[31:16]};
                  vr_in    = '0;
                  len_in   = '0;
                  if (tag_in == dicomdf_pkg::TAG_ITEM ||
                      tag_in == dicomdf_pkg::TAG_ITEM_END ||
                      tag_in == dicomdf_pkg::TAG_SEQ_END) begin
                     phase_in        = dicomdf_pkg::PH_SKIP;
                     res_valid       = 1'b1;
                     res.element_tag = tag_in;
                     if (tag_in == dicomdf_pkg::TAG_ITEM) begin
                        res.kind = dicomdf_pkg::KIND_ITEM;
                     end else if (tag_in == dicomdf_pkg::TAG_ITEM_END) begin
                        res.kind = dicomdf_pkg::KIND_ITEM_END;
                     end else begin
                        res.kind = dicomdf_pkg::KIND_SEQ_END;
                     end
                  end else begin
                     phase_in = dicomdf_pkg::PH_VR;
                  end
               end
            end
            dicomdf_pkg::PH_VR: begin
               if (count_in < 8'd2) begin
                  vr_in = vr_in | (16'(step_byte) << {count_in[0], 3'b000});
               end
               count_in = count_in + 8'd1;
               if (count_in == (dicomdf_pkg::long_form(vr_in) ? 8'd4 : 8'd2)) begin
                  phase_in = dicomdf_pkg::PH_LEN;
                  count_in = '0;
                  len_in   = '0;
               end
            end
            dicomdf_pkg::PH_LEN: begin
               len_in   = len_in | (32'(step_byte) << {count_in[1:0], 3'b000});
               count_in = count_in + 8'd1;
               if (count_in >= (dicomdf_pkg::long_form(vr_in) ? 8'd4 : 8'd2)) begin
                  count_in         = '0;
                  res_valid        = 1'b1;
                  res.kind         = dicomdf_pkg::KIND_HEADER;
                  res.element_tag  = tag_in;
                  res.value_repr   = vr_in;
                  res.elem_length  = len_in;
                  if (len_in != '0 && len_in != dicomdf_pkg::LEN_UNDEF) begin
                     phase_in  = dicomdf_pkg::PH_VAL;
                     remain_in = len_in;
                  end else begin
                     phase_in = dicomdf_pkg::PH_TAG;
                     tag_in   = '0;
                  end
               end
            end
            dicomdf_pkg::PH_SKIP: begin
               count_in = count_in + 8'd1;
               if (count_in >= 8'd4) begin
                  count_in = '0;
                  phase_in = dicomdf_pkg::PH_TAG;
                  tag_in   = '0;
               end
            end
            dicomdf_pkg::PH_VAL: begin
               remain_in        = remain_in - 32'd1;
               last             = (remain_in == '0);
               res_valid        = 1'b1;
               res.kind         = dicomdf_pkg::KIND_VALUE;
               res.element_tag  = tag_in;
               res.value_repr   = vr_in;
               res.elem_length  = len_in;
               res.value_byte   = step_byte;
               res.last_value   = last;
               if (last) begin
                  phase_in = dicomdf_pkg::PH_TAG;
                  count_in = '0;
                  tag_in   = '0;
               end
            end
            default: begin
               // halted or preamble already handled: hold
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= dicomdf_pkg::PH_PRE;
         count_ff  <= '0;
         tag_ff    <= '0;
         vr_ff     <= '0;
         len_ff    <= '0;
         remain_ff <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         tag_ff    <= tag_in;
         vr_ff     <= vr_in;
         len_ff    <= len_in;
         remain_ff <= remain_in;
      end
   end

endmodule

// File: hw/rtl/dicom_element_header_deframer_top.sv
// Top level of the DICOM explicit-VR little-endian element header deframer.
//
// Bytes of a DICOM file enter on the req_ channel, one item per byte, with
// req_restart set on a byte to begin a new file at that byte. Results leave on
// the rsp_ channel: element headers, item and delimiter records, value bytes
// with a last marker, and a single not-DICOM record when the magic check fails
// (after which bytes are dropped until a restart). A byte produces zero or one
// result item.
// The csr_ port holds expect_preamble (address 0, reset 1); it takes effect
// at the next restart; reset itself always expects the preamble. It must be
// written by the user only while the block is idle; the block does not enforce
// this. A result passes from the input register, which takes the byte, through
// the framing logic into the output register. Throughput: one byte per clock,
// between the two registers, while the receiver does not stall.
// Reset clears the parser to the file start with the preamble expected and
// empties both registers. When the receiver stalls, the output register holds
// its item and the input register can still take one more byte; then req_ready
// drops until the result is taken.
module dicom_element_header_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_element_tag,
   output logic [15:0] rsp_value_repr,
   output logic [31:0] rsp_elem_length,
   output logic [7:0]  rsp_value_byte,
   output logic        rsp_last_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic expect_preamble_ff;
   logic csr_write;
   logic csr_hit;

   logic       stage_valid_ff;
   logic [7:0] stage_byte_ff;
   logic       stage_restart_ff;

   logic                    out_valid_ff;
   dicomdf_pkg::result_type out_ff;

   logic                    out_free;
   logic                    step_en;
   logic                    res_valid;
   dicomdf_pkg::result_type res;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == dicomdf_pkg::CSR_IDX_EXPECT_PREAMBLE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {31'b0, expect_preamble_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_preamble_ff <= 1'b1;
      end else if (csr_write && csr_hit) begin
         expect_preamble_ff <= csr_pwdata[0];
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_en   = stage_valid_ff && out_free;
   assign req_ready = !stage_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         stage_valid_ff <= 1'b1;
      end else if (step_en) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_byte_ff    <= req_stream_byte;
         stage_restart_ff <= req_restart;
      end
   end

   dicomdf_step u_step (
      .clock           (clock),
      .reset           (reset),
      .expect_preamble (expect_preamble_ff),
      .step_en         (step_en),
      .step_byte       (stage_byte_ff),
      .step_restart    (stage_restart_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en) begin
         out_valid_ff <= res_valid;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // load only real results so a stalled item is never overwritten
   always_ff @(posedge clock) begin
      if (step_en && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_element_tag  = out_ff.element_tag;
   assign rsp_value_repr   = out_ff.value_repr;
   assign rsp_elem_length  = out_ff.elem_length;
   assign rsp_value_byte   = out_ff.value_byte;
   assign rsp_last_value   = out_ff.last_value;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the DICOM element header deframer top level.
module testbench;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS = 40;
   localparam logic [2:0] EXPECT_PREAMBLE_ADDR =
      {dicomdf_pkg::CSR_IDX_EXPECT_PREAMBLE, 2'b00};

   localparam logic [15:0] VR_AE = 16'h4541;
   localparam logic [15:0] VR_UI = 16'h4955;
   localparam logic [15:0] VR_LO = 16'h4F4C;
   localparam logic [15:0] VR_US = 16'h5355;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_stream_byte;
   logic        req_restart;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_element_tag;
   logic [15:0] rsp_value_repr;
   logic [31:0] rsp_elem_length;
   logic [7:0]  rsp_value_byte;
   logic        rsp_last_value;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dicom_element_header_deframer_top DUT (.*);

   always #2 clock = ~clock;

   // parser state as the block should hold it
   logic                   cfg_preamble;
   dicomdf_pkg::phase_type ph;
   logic [7:0]             cnt;
   logic [31:0]            tag_acc;
   logic [15:0]            vr_acc;
   logic [31:0]            len_acc;
   logic [31:0]            remaining;

   dicomdf_pkg::result_type frames_due[$];
   int unsigned bytes_sent = 0;
   int unsigned frames_seen = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   logic        fresh_file = 1'b0;
   logic        steady = 1'b0;

   function automatic logic has_long_length(input logic [15:0] vr);
      return vr == dicomdf_pkg::VR_OB || vr == dicomdf_pkg::VR_OW ||
             vr == dicomdf_pkg::VR_SQ || vr == dicomdf_pkg::VR_UT;
   endfunction

   task automatic start_file();
      ph = cfg_preamble ? dicomdf_pkg::PH_PRE : dicomdf_pkg::PH_TAG;
      cnt = '0;
      tag_acc = '0;
      vr_acc = '0;
      len_acc = '0;
      remaining = '0;
   endtask

   // append a record to the outstanding list
   task automatic queue_frame(input dicomdf_pkg::result_type r);
      frames_due.insert(frames_due.size(), r);
   endtask

   // advance the parser by one byte and queue the record it yields, if any
   task automatic frame_byte(input logic [7:0] b, input logic rs);
      dicomdf_pkg::result_type r;
      logic [31:0]             lane_b;
      r = '0;
      if (rs)
         start_file();
      if (ph == dicomdf_pkg::PH_PRE) begin
         if (cnt < dicomdf_pkg::PREAMBLE_BYTES) begin
            cnt++;
            return;
         end
         ph = dicomdf_pkg::PH_MAGIC;
         cnt = '0;
         tag_acc = '0;
      end
      lane_b = 32'(b) << (8 * cnt[1:0]);
      case (ph)
         dicomdf_pkg::PH_MAGIC: begin
            tag_acc |= lane_b;
            cnt++;
            if (cnt == 4) begin
               cnt = '0;
               if (tag_acc == dicomdf_pkg::MAGIC_WORD) begin
                  ph = dicomdf_pkg::PH_TAG;
               end else begin
                  ph = dicomdf_pkg::PH_HALT;
                  r.kind = dicomdf_pkg::KIND_NOT_DCM;
                  queue_frame(r);
               end
               tag_acc = '0;
            end
         end
         dicomdf_pkg::PH_TAG: begin
            tag_acc |= lane_b;
            cnt++;
            if (cnt == 4) begin
               cnt = '0;
               tag_acc = {tag_acc[15:0], tag_acc[31:16]};
               vr_acc = '0;
               len_acc = '0;
               if (tag_acc == dicomdf_pkg::TAG_ITEM ||
                   tag_acc == dicomdf_pkg::TAG_ITEM_END ||
                   tag_acc == dicomdf_pkg::TAG_SEQ_END) begin
                  if (tag_acc == dicomdf_pkg::TAG_ITEM)
                     r.kind = dicomdf_pkg::KIND_ITEM;
                  else if (tag_acc == dicomdf_pkg::TAG_ITEM_END)
                     r.kind = dicomdf_pkg::KIND_ITEM_END;
                  else
                     r.kind = dicomdf_pkg::KIND_SEQ_END;
                  r.element_tag = tag_acc;
                  queue_frame(r);
                  ph = dicomdf_pkg::PH_SKIP;
               end else begin
                  ph = dicomdf_pkg::PH_VR;
               end
            end
         end
         dicomdf_pkg::PH_VR: begin
            if (cnt < 2)
               vr_acc |= lane_b[15:0];
            cnt++;
            if (cnt == (has_long_length(vr_acc) ? 4 : 2)) begin
               ph = dicomdf_pkg::PH_LEN;
               cnt = '0;
               len_acc = '0;
            end
         end
         dicomdf_pkg::PH_LEN: begin
            len_acc |= lane_b;
            cnt++;
            if (cnt == (has_long_length(vr_acc) ? 4 : 2)) begin
               cnt = '0;
               r.kind = dicomdf_pkg::KIND_HEADER;
               r.element_tag = tag_acc;
               r.value_repr = vr_acc;
               r.elem_length = len_acc;
               queue_frame(r);
               if (len_acc != 0 && len_acc != dicomdf_pkg::LEN_UNDEF) begin
                  ph = dicomdf_pkg::PH_VAL;
                  remaining = len_acc;
               end else begin
                  ph = dicomdf_pkg::PH_TAG;
                  tag_acc = '0;
               end
            end
         end
         dicomdf_pkg::PH_SKIP: begin
            cnt++;
            if (cnt >= 4) begin
               cnt = '0;
               ph = dicomdf_pkg::PH_TAG;
               tag_acc = '0;
            end
         end
         dicomdf_pkg::PH_VAL: begin
            remaining = remaining - 1;
            r.kind = dicomdf_pkg::KIND_VALUE;
            r.element_tag = tag_acc;
            r.value_repr = vr_acc;
            r.elem_length = len_acc;
            r.value_byte = b;
            r.last_value = (remaining == 0);
            queue_frame(r);
            if (r.last_value) begin
               ph = dicomdf_pkg::PH_TAG;
               cnt = '0;
               tag_acc = '0;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s = %h, expected %h",
                                   frames_seen, name, got, want));
   endtask

   always @(posedge clock) begin
      dicomdf_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         frames_seen++;
         if (frames_due.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      frames_seen));
         end else begin
            want = frames_due.pop_front();
            check_field("kind", 32'(rsp_kind), 32'(want.kind));
            check_field("element_tag", rsp_element_tag, want.element_tag);
            check_field("value_repr", 32'(rsp_value_repr), 32'(want.value_repr));
            check_field("elem_length", rsp_elem_length, want.elem_length);
            check_field("value_byte", 32'(rsp_value_byte), 32'(want.value_byte));
            check_field("last_value", 32'(rsp_last_value), 32'(want.last_value));
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(0, 99) >= 8);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("[dicom_element_header_deframer_top] ERROR");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic rs);
      while (!steady && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= b;
      req_restart <= rs;
      do @(posedge clock); while (!req_ready);
      frame_byte(b, rs);
      bytes_sent++;
   endtask

   // first byte of a new file carries the restart
   task automatic feed(input logic [7:0] b);
      send_byte(b, fresh_file);
      fresh_file = 1'b0;
   endtask

   task automatic send_word(input logic [31:0] w);
      feed(w[7:0]);
      feed(w[15:8]);
      feed(w[23:16]);
      feed(w[31:24]);
   endtask

   task automatic send_tag(input logic [31:0] tag);
      send_word({tag[15:0], tag[31:16]});
   endtask

   task automatic send_marker(input logic [31:0] tag);
      send_tag(tag);
      send_word($urandom);
   endtask

   task automatic send_element(input logic [31:0] tag, input logic [15:0] vr,
                               input logic [31:0] len, input int unsigned nvals);
      send_tag(tag);
      feed(vr[7:0]);
      feed(vr[15:8]);
      if (has_long_length(vr)) begin
         feed(8'($urandom));
         feed(8'($urandom));
         send_word(len);
      end else begin
         feed(len[7:0]);
         feed(len[15:8]);
      end
      repeat (nvals) feed(8'($urandom));
   endtask

   // hold the input idle until every record is out, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apb_cycle(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= EXPECT_PREAMBLE_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_preamble_mode(input logic v);
      logic [31:0] rd;
      apb_cycle(1'b1, {31'b0, v}, rd);
      cfg_preamble = v;
      @(posedge clock);
      apb_cycle(1'b0, '0, rd);
      if (rd !== {31'b0, v})
         report_mismatch($sformatf("expect_preamble reads %h, expected %h", rd, v));
   endtask

   task automatic random_element(output logic unfinished);
      int unsigned pick;
      int unsigned nvals;
      logic [31:0] tag;
      logic [31:0] len;
      logic [15:0] vr;
      unfinished = 1'b0;
      if ($urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 2))
            0: send_marker(dicomdf_pkg::TAG_ITEM);
            1: send_marker(dicomdf_pkg::TAG_ITEM_END);
            default: send_marker(dicomdf_pkg::TAG_SEQ_END);
         endcase
         return;
      end
      tag = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         case (pick)
            0: vr = dicomdf_pkg::VR_OB;
            1: vr = dicomdf_pkg::VR_OW;
            2: vr = dicomdf_pkg::VR_SQ;
            default: vr = dicomdf_pkg::VR_UT;
         endcase
      end else if (pick < 9) begin
         vr = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90))};
      end else begin
         vr = 16'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         len = has_long_length(vr) ? dicomdf_pkg::LEN_UNDEF : 32'd0;
         nvals = 0;
      end else if (pick < 18) begin
         // too long to finish: send a few bytes and abandon the file
         len = has_long_length(vr) ? ($urandom | 32'h100)
                                   : 32'($urandom_range(256, 65535));
         nvals = $urandom_range(0, 6);
         unfinished = 1'b1;
      end else begin
         len = 32'($urandom_range(1, 8));
         nvals = len;
      end
      send_element(tag, vr, len, nvals);
   endtask

   task automatic random_file();
      int unsigned n_left;
      logic        unfinished;
      logic [31:0] magic;
      fresh_file = 1'b1;
      if (cfg_preamble) begin
         repeat (dicomdf_pkg::PREAMBLE_BYTES) feed(8'($urandom));
         magic = dicomdf_pkg::MAGIC_WORD;
         if ($urandom_range(0, 7) == 0)
            magic ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3));
         send_word(magic);
         if (magic != dicomdf_pkg::MAGIC_WORD) begin
            repeat ($urandom_range(1, 4)) feed(8'($urandom));
            return;
         end
      end
      n_left = $urandom_range(2, 10);
      unfinished = 1'b0;
      while (n_left != 0 && !unfinished) begin
         random_element(unfinished);
         n_left--;
      end
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
   endtask

   task automatic random_phase(input logic mode, input int unsigned budget);
      int unsigned stop_at;
      drain();
      set_preamble_mode(mode);
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at)
         random_file();
   endtask

   // reset state: preamble expected, no restart on the first file
   task automatic test_preamble_magic();
      repeat (dicomdf_pkg::PREAMBLE_BYTES) feed(8'($urandom));
      send_word(dicomdf_pkg::MAGIC_WORD);
      send_element(32'h0002_0010, VR_UI, 32'd2, 2);
   endtask

   task automatic test_magic_mismatch();
      fresh_file = 1'b1;
      repeat (dicomdf_pkg::PREAMBLE_BYTES) feed(8'($urandom));
      send_word(dicomdf_pkg::MAGIC_WORD ^ 32'h0100_0000);
      repeat (3) feed(8'($urandom));
   endtask

   task automatic test_element_forms();
      drain();
      set_preamble_mode(1'b0);
      fresh_file = 1'b1;
      send_element(32'h0000_0000, VR_AE, 32'd1, 1);
      send_element(32'hFFFF_FFFF, dicomdf_pkg::VR_OW, 32'd2, 2);
      send_element(32'h0008_0016, VR_UI, 32'd0, 0);
      send_element(32'h7FE0_0010, dicomdf_pkg::VR_OB, 32'd3, 3);
   endtask

   task automatic test_sequence_markers();
      send_element(32'h0040_0275, dicomdf_pkg::VR_SQ, dicomdf_pkg::LEN_UNDEF, 0);
      send_marker(dicomdf_pkg::TAG_ITEM);
      send_element(32'h0028_0010, VR_US, 32'd2, 2);
      send_marker(dicomdf_pkg::TAG_ITEM_END);
      send_marker(dicomdf_pkg::TAG_SEQ_END);
   endtask

   task automatic test_truncated_lengths();
      // a short length of all ones is a real length, not undefined
      send_element(32'h0010_0010, VR_LO, 32'h0000_FFFF, 3);
      fresh_file = 1'b1;
      send_element(32'h0042_0011, dicomdf_pkg::VR_UT, 32'hFFFF_FFFE, 2);
      fresh_file = 1'b1;
      send_element(32'h0020_000D, VR_UI, 32'd1, 1);
   endtask

   task automatic test_random_stream();
      random_phase(1'b0, 160);
      steady <= 1'b1;
      random_phase(1'b1, 120);
      steady <= 1'b0;
      random_phase(1'b0, 150);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_stream_byte = '0;
      req_restart = 1'b0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_preamble = 1'b1;
      start_file();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_preamble_magic();
      test_magic_mismatch();
      test_element_forms();
      test_sequence_markers();
      test_truncated_lengths();
      test_random_stream();

      drain();
      if (mismatches == 0 && frames_due.size() == 0)
         $display("[dicom_element_header_deframer_top] OK");
      else
         $display("[dicom_element_header_deframer_top] ERROR");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/dicomdf_pkg.sv
hw/rtl/dicomdf_step.sv
hw/rtl/dicom_element_header_deframer_top.sv
tb/testbench.sv
